/* src/vslp_pkg.sv */
`default_nettype none

package vslp_pkg;

    // defaults for the top-level parameters
    localparam int SAMPLE_WIDTH_DEF    = 16;
    localparam int EXP_TABLE_DEPTH_DEF = 256;

    // fixed field and register widths
    localparam int TIME_WIDTH  = 16;
    localparam int TAU_WIDTH   = 20;
    localparam logic [TAU_WIDTH-1:0] TAU_RESET = 20'd1024;

    // dt/tau is unsigned q4.16, so the quotient has 20 bits
    localparam int X_FRAC_BITS   = 16;
    localparam int X_LIMIT_SHIFT = 4;
    localparam int X_WIDTH       = X_FRAC_BITS + X_LIMIT_SHIFT;

    // table position keeps 20 fraction bits
    localparam int POS_FRAC_BITS = 20;

    // alpha is unsigned q1.16 with 1.0 held as 65536
    localparam int ALPHA_WIDTH = 17;
    localparam logic [ALPHA_WIDTH-1:0] ONE_Q16 = 17'h10000;
    localparam int ONE_SHIFT = 16;

    // first operand of the shared multiplier
    localparam int MAC_A_WIDTH = X_WIDTH + 1;

    // request to the shared multiply-accumulate unit
    typedef struct packed {
        logic go;
        logic accumulate;
    } mac_ctl_t;

endpackage

`default_nettype wire

/* src/vslp_div.sv */
`default_nettype none

// restoring divider, one quotient bit per cycle: (dt << 16) / tau
// caller guarantees dt < 16*tau, so only the low 20 quotient bits are live
module vslp_div (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             start,
    input  wire logic [vslp_pkg::TIME_WIDTH-1:0]  dt,
    input  wire logic [vslp_pkg::TAU_WIDTH-1:0]   tau,
    output logic                                  done,
    output logic [vslp_pkg::X_WIDTH-1:0]          quotient
);

    localparam int TW    = vslp_pkg::TAU_WIDTH;
    localparam int XW    = vslp_pkg::X_WIDTH;
    localparam int CNT_W = $clog2(XW);
    localparam int REM_PAD = TW - vslp_pkg::TIME_WIDTH + vslp_pkg::X_LIMIT_SHIFT;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [TW-1:0]    rem_reg;
    logic [TW-1:0]    div_reg;
    logic [XW-1:0]    low_reg;
    logic [XW-1:0]    quo_reg;

    logic [TW:0]      trial;
    logic [TW:0]      diff;
    logic             fits;

    // one compare-subtract step
    always_comb begin
        trial = {rem_reg, low_reg[XW-1]};
        diff  = trial - {1'b0, div_reg};
        fits  = trial >= {1'b0, div_reg};
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(XW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: the top dividend bits are below tau, so they seed the remainder
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= {{REM_PAD{1'b0}}, dt[vslp_pkg::TIME_WIDTH-1:vslp_pkg::X_LIMIT_SHIFT]};
            low_reg <= {dt[vslp_pkg::X_LIMIT_SHIFT-1:0], {vslp_pkg::X_FRAC_BITS{1'b0}}};
            div_reg <= tau;
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[TW-1:0] : trial[TW-1:0];
            low_reg <= {low_reg[XW-2:0], 1'b0};
            quo_reg <= {quo_reg[XW-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

/* src/vslp_mac.sv */
`default_nettype none

// shared signed multiply-accumulate: product registered, then summed
module vslp_mac #(
    parameter int B_WIDTH = 21
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire vslp_pkg::mac_ctl_t                      ctl,
    input  wire logic signed [vslp_pkg::MAC_A_WIDTH-1:0] op_a,
    input  wire logic signed [B_WIDTH-1:0]               op_b,
    output logic signed [vslp_pkg::MAC_A_WIDTH+B_WIDTH:0] acc
);

    localparam int PW = vslp_pkg::MAC_A_WIDTH + B_WIDTH;

    logic              go_reg;
    logic              accum_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [PW:0]   acc_reg;

    // control flags are registered in step with the product
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            go_reg    <= 1'b0;
            accum_reg <= 1'b0;
        end else begin
            go_reg    <= ctl.go;
            accum_reg <= ctl.accumulate;
        end
    end

    // multiply stage
    always_ff @(posedge aclk) begin
        if (ctl.go) begin
            prod_reg <= op_a * op_b;
        end
    end

    // accumulate stage, holds between requests
    always_ff @(posedge aclk) begin
        if (go_reg) begin
            acc_reg <= (accum_reg ? acc_reg : '0) + {prod_reg[PW-1], prod_reg};
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

/* src/vslp_exp_rom.sv */
`default_nettype none

// exp(-16k/depth) table in unsigned q1.16, k = 0..depth, registered read
module vslp_exp_rom #(
    parameter int DEPTH = 256
) (
    input  wire logic                          aclk,
    input  wire logic [$clog2(DEPTH+1)-1:0]    addr,
    output logic [vslp_pkg::ALPHA_WIDTH-1:0]   data
);

    localparam int AW = $clog2(DEPTH + 1);
    localparam int AL = vslp_pkg::ALPHA_WIDTH;

    typedef logic [AL-1:0] tab_t [DEPTH+1];

    // shift-subtract quotient, evaluated while the table is built
    function automatic logic [95:0] quot96(logic [95:0] num, logic [95:0] den);
        logic [95:0] rem;
        logic [95:0] quo;
        int          b;
        rem = '0;
        quo = '0;
        for (b = 95; b >= 0; b--) begin
            rem = {rem[94:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // ratio by truncated taylor series in q0.32, then repeated rounded products
    function automatic tab_t build_tab();
        logic [95:0] r;
        logic [95:0] term;
        logic [95:0] v;
        logic [95:0] e;
        int          n;
        int          k;
        tab_t        t;
        r    = 96'h1_0000_0000;
        term = 96'h1_0000_0000;
        v    = 96'h1_0000_0000;
        for (n = 1; n <= 40 && term != 96'd0; n++) begin
            term = quot96(term * 96'd16, 96'(DEPTH) * 96'(n));
            if (n[0] == 1'b1) begin
                r = r - term;
            end else begin
                r = r + term;
            end
        end
        if (r > 96'hFFFF_FFFF) begin
            r = 96'hFFFF_FFFF;
        end
        t[0] = vslp_pkg::ONE_Q16;
        for (k = 1; k <= DEPTH; k++) begin
            v    = (v * r + 96'h8000_0000) >> 32;
            e    = (v + 96'h8000) >> 16;
            t[k] = e[AL-1:0];
        end
        return t;
    endfunction

    localparam tab_t EXP_TAB = build_tab();

    logic [AL-1:0] data_reg;

    // registered table read
    always_ff @(posedge aclk) begin
        if (addr <= AW'(DEPTH)) begin
            data_reg <= EXP_TAB[addr];
        end else begin
            data_reg <= '0;
        end
    end

    assign data = data_reg;

endmodule

`default_nettype wire

/* src/variable_step_lowpass_filter_top.sv */
`default_nettype none

// accepted beat to result beat: the 20-step serial divider for dt/tau, then the
//   single shared multiplier used four times (twice when dt >= 16*tau, skipping the
//   divider); a new beat is taken only after the previous result is registered
// a new input beat is taken while the previous result beat still waits
// reset (aresetn low, synchronous): output value 0, time constant 1024 (1 s)
module variable_step_lowpass_filter_top #(
    parameter int SAMPLE_WIDTH    = vslp_pkg::SAMPLE_WIDTH_DEF,
    parameter int EXP_TABLE_DEPTH = vslp_pkg::EXP_TABLE_DEPTH_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // configuration: time constant
    input  wire logic                                   cfg_wr_en,
    input  wire logic [vslp_pkg::TAU_WIDTH-1:0]         cfg_wr_data,
    // input stream
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // fields from bit 0: sample, elapsed_time
    input  wire logic [((SAMPLE_WIDTH+vslp_pkg::TIME_WIDTH+7)/8)*8-1:0] s_tdata,
    // result stream
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // fields from bit 0: filtered
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]           m_tdata
);

    localparam int SW      = SAMPLE_WIDTH;
    localparam int TW      = vslp_pkg::TIME_WIDTH;
    localparam int UW      = vslp_pkg::TAU_WIDTH;
    localparam int XW      = vslp_pkg::X_WIDTH;
    localparam int AL      = vslp_pkg::ALPHA_WIDTH;
    localparam int FB      = vslp_pkg::POS_FRAC_BITS;
    localparam int LS      = vslp_pkg::X_LIMIT_SHIFT;
    localparam int OS      = vslp_pkg::ONE_SHIFT;
    localparam int MA      = vslp_pkg::MAC_A_WIDTH;
    localparam int MB      = ((SW > XW) ? SW : XW) + 1;
    localparam int ACC_W   = MA + MB + 1;
    localparam int IDX_W   = $clog2(EXP_TABLE_DEPTH);
    localparam int ROM_AW  = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int OUT_TW  = ((SW + 7) / 8) * 8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL_POS,
        ST_WAIT_POS,
        ST_ROM_HI,
        ST_ROM_LO,
        ST_INTERP,
        ST_WAIT_INTERP,
        ST_ALPHA,
        ST_BLEND,
        ST_WAIT_BLEND,
        ST_FINISH
    } state_t;

    // registers
    state_t              state_reg, state_next;
    logic [UW-1:0]       tau_reg, tau_next;
    logic signed [SW-1:0] out_val_reg, out_val_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [SW-1:0]       m_data_reg, m_data_next;
    logic signed [SW-1:0] sample_reg, sample_next;
    logic                long_reg, long_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [FB-1:0]       frac_reg, frac_next;
    logic [AL-1:0]       hi_reg, hi_next;
    logic [AL-1:0]       alpha_reg, alpha_next;

    // internal signals
    logic                 in_beat;
    logic signed [SW-1:0] in_sample;
    logic [TW-1:0]        in_dt;
    logic [UW-1:0]        tau_eff;
    logic                 in_long;
    logic                 div_start;
    logic                 div_done;
    logic [XW-1:0]        div_quo;
    vslp_pkg::mac_ctl_t   mac_ctl;
    logic signed [MA-1:0] mac_a;
    logic signed [MB-1:0] mac_b;
    logic signed [ACC_W-1:0] mac_acc;
    logic [ROM_AW-1:0]    rom_addr;
    logic [AL-1:0]        rom_data;
    logic [AL-1:0]        lo_clamp;
    logic [AL-1:0]        alpha_now;
    logic [ACC_W-1:0]     acc_round;
    logic                 out_free;

    // input field unpacking and the long-step test
    always_comb begin
        in_beat   = s_tvalid && s_tready;
        in_sample = s_tdata[SW-1:0];
        in_dt     = s_tdata[SW +: TW];
        tau_eff   = (tau_reg == '0) ? UW'(1) : tau_reg;
        in_long   = {{(UW + LS - TW){1'b0}}, in_dt} >= {tau_eff, {LS{1'b0}}};
        div_start = in_beat && !in_long;
    end

    vslp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dt       (in_dt),
        .tau      (tau_eff),
        .done     (div_done),
        .quotient (div_quo)
    );

    vslp_mac #(
        .B_WIDTH (MB)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .op_a    (mac_a),
        .op_b    (mac_b),
        .acc     (mac_acc)
    );

    vslp_exp_rom #(
        .DEPTH (EXP_TABLE_DEPTH)
    ) u_rom (
        .aclk (aclk),
        .addr (rom_addr),
        .data (rom_data)
    );

    // interpolation and result rounding
    always_comb begin
        lo_clamp  = (rom_data > hi_reg) ? hi_reg : rom_data;
        alpha_now = long_reg ? '0 : (hi_reg - mac_acc[FB +: AL]);
        // truncate toward zero on the divide by 65536
        acc_round = mac_acc + {{(ACC_W - OS){1'b0}}, {OS{mac_acc[ACC_W-1]}}};
        out_free  = !m_tvalid_reg || m_tready;
        rom_addr  = (state_reg == ST_ROM_HI) ? ROM_AW'(mac_acc[FB +: IDX_W])
                                             : (ROM_AW'(idx_reg) + ROM_AW'(1));
    end

    // shared multiplier operand select
    always_comb begin
        mac_ctl = '0;
        mac_a   = '0;
        mac_b   = '0;
        case (state_reg)
            ST_MUL_POS: begin
                mac_ctl.go = 1'b1;
                mac_a      = {1'b0, div_quo};
                mac_b      = MB'(EXP_TABLE_DEPTH);
            end
            ST_INTERP: begin
                mac_ctl.go = 1'b1;
                mac_a      = MA'(hi_reg - lo_clamp);
                mac_b      = MB'(frac_reg);
            end
            ST_ALPHA: begin
                mac_ctl.go = 1'b1;
                mac_a      = MA'(alpha_now);
                mac_b      = MB'(out_val_reg);
            end
            ST_BLEND: begin
                mac_ctl.go         = 1'b1;
                mac_ctl.accumulate = 1'b1;
                mac_a              = MA'(vslp_pkg::ONE_Q16 - alpha_reg);
                mac_b              = MB'(sample_reg);
            end
            default: begin
                mac_ctl = '0;
            end
        endcase
    end

    // sequencer next state
    always_comb begin
        state_next    = state_reg;
        tau_next      = cfg_wr_en ? cfg_wr_data : tau_reg;
        out_val_next  = out_val_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_data_next   = m_data_reg;
        sample_next   = sample_reg;
        long_next     = long_reg;
        idx_next      = idx_reg;
        frac_next     = frac_reg;
        hi_next       = hi_reg;
        alpha_next    = alpha_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    sample_next = in_sample;
                    long_next   = in_long;
                    state_next  = in_long ? ST_ALPHA : ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_MUL_POS;
                end
            end
            ST_MUL_POS: begin
                state_next = ST_WAIT_POS;
            end
            ST_WAIT_POS: begin
                state_next = ST_ROM_HI;
            end
            ST_ROM_HI: begin
                idx_next   = mac_acc[FB +: IDX_W];
                frac_next  = mac_acc[FB-1:0];
                state_next = ST_ROM_LO;
            end
            ST_ROM_LO: begin
                hi_next    = rom_data;
                state_next = ST_INTERP;
            end
            ST_INTERP: begin
                state_next = ST_WAIT_INTERP;
            end
            ST_WAIT_INTERP: begin
                state_next = ST_ALPHA;
            end
            ST_ALPHA: begin
                alpha_next = alpha_now;
                state_next = ST_BLEND;
            end
            ST_BLEND: begin
                state_next = ST_WAIT_BLEND;
            end
            ST_WAIT_BLEND: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_val_next  = acc_round[OS +: SW];
                    m_data_next   = acc_round[OS +: SW];
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            tau_reg      <= vslp_pkg::TAU_RESET;
            out_val_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            long_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            tau_reg      <= tau_next;
            out_val_reg  <= out_val_next;
            m_tvalid_reg <= m_tvalid_next;
            long_reg     <= long_next;
        end
        m_data_reg <= m_data_next;
        sample_reg <= sample_next;
        idx_reg    <= idx_next;
        frac_reg   <= frac_next;
        hi_reg     <= hi_next;
        alpha_reg  <= alpha_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_TW'(m_data_reg);

endmodule

`default_nettype wire

/* tb/variable_step_lowpass_filter_top_test.sv */
module variable_step_lowpass_filter_top_test;

    localparam int SW          = vslp_pkg::SAMPLE_WIDTH_DEF;
    localparam int TW          = vslp_pkg::TIME_WIDTH;
    localparam int LUT_DEPTH   = vslp_pkg::EXP_TABLE_DEPTH_DEF;
    localparam int S_DATA_W    = ((SW + TW + 7) / 8) * 8;
    localparam int M_DATA_W    = ((SW + 7) / 8) * 8;
    localparam int STEP_LIMIT  = 16;
    localparam int SETTLE      = 40;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_BEATS = 181;
    localparam int HOLD_AFTER  = 60;
    localparam int HOLD_CYCLES = 500;
    localparam logic [vslp_pkg::TAU_WIDTH-1:0] TAU_MAX = '1;

    // one input beat, sample in the low bits
    typedef struct packed {
        logic [TW-1:0]        dt;
        logic signed [SW-1:0] sample;
    } sensor_beat_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             cfg_wr_en = 1'b0;
    logic [vslp_pkg::TAU_WIDTH-1:0]   cfg_wr_data = '0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [S_DATA_W-1:0]              s_tdata = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [M_DATA_W-1:0]              m_tdata;

    variable_step_lowpass_filter_top dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    always #10 aclk = ~aclk;

    // scoreboard and model state
    sensor_beat_t            pending_beats[$];
    logic signed [SW-1:0]    expected_outputs[$];
    longint unsigned         decay_lut[0:LUT_DEPTH];
    logic [vslp_pkg::TAU_WIDTH-1:0] tau_model = vslp_pkg::TAU_RESET;
    longint                  filt_state = 0;
    int                      items_queued = 0;
    int                      items_taken = 0;
    int                      rx_count = 0;
    int                      fail_count = 0;
    int                      send_idle_pct = 0;
    int                      recv_idle_pct = 0;
    int                      hold_left = 0;
    bit                      hold_done = 1'b0;
    logic                    in_taken = 1'b0;

    // exp(-16k/depth) table in unsigned q1.16, integer-only construction
    function automatic void build_decay_lut();
        longint unsigned ratio, term, v;
        ratio = 64'd1 << 32;
        term  = 64'd1 << 32;
        v     = 64'd1 << 32;
        for (int n = 1; n <= 40 && term != 0; n++) begin
            term = (term * STEP_LIMIT) / (longint'(LUT_DEPTH) * n);
            if (n % 2 == 1) ratio = ratio - term;
            else ratio = ratio + term;
        end
        if (ratio > 64'hFFFF_FFFF) ratio = 64'hFFFF_FFFF;
        decay_lut[0] = 64'd65536;
        for (int k = 1; k <= LUT_DEPTH; k++) begin
            v = (v * ratio + (64'd1 << 31)) >> 32;
            decay_lut[k] = (v + (64'd1 << 15)) >> 16;
        end
    endfunction

    // alpha = exp(-dt/tau) by table lookup with linear interpolation
    function automatic longint unsigned decay_factor(logic [TW-1:0] dt,
                                                     logic [vslp_pkg::TAU_WIDTH-1:0] tau);
        longint unsigned t, x, pos, idx, frac, hi, lo;
        t = (tau == 0) ? 64'd1 : longint'(tau);
        if (longint'(dt) >= STEP_LIMIT * t) return 0;
        x    = (longint'(dt) << vslp_pkg::X_FRAC_BITS) / t;
        pos  = x * LUT_DEPTH;
        idx  = pos >> vslp_pkg::POS_FRAC_BITS;
        frac = pos & ((64'd1 << vslp_pkg::POS_FRAC_BITS) - 1);
        if (idx >= LUT_DEPTH) return 0;
        hi = decay_lut[idx];
        lo = decay_lut[idx + 1];
        if (lo > hi) lo = hi;
        return hi - (((hi - lo) * frac) >> vslp_pkg::POS_FRAC_BITS);
    endfunction

    // update the filter output for one accepted sample
    function automatic logic signed [SW-1:0] advance_filter(sensor_beat_t beat);
        longint alpha, smp, acc;
        alpha = longint'(decay_factor(beat.dt, tau_model));
        smp   = beat.sample;
        acc   = alpha * filt_state + (longint'(vslp_pkg::ONE_Q16) - alpha) * smp;
        filt_state = acc / longint'(vslp_pkg::ONE_Q16);
        return filt_state[SW-1:0];
    endfunction

    // random beat, dt spread around the long-step boundary of this tau
    function automatic sensor_beat_t random_beat(logic [vslp_pkg::TAU_WIDTH-1:0] tau);
        sensor_beat_t beat;
        longint unsigned span, top;
        int unsigned pick;
        span = STEP_LIMIT * ((tau == 0) ? 64'd1 : longint'(tau));
        top  = (span - 1 > 65535) ? 65535 : span - 1;
        pick = $urandom_range(0, 7);
        if (pick < 2) beat.dt = TW'($urandom);
        else if (pick < 6) beat.dt = TW'($urandom_range(0, int'(top)));
        else if (pick == 6) beat.dt = '0;
        else if (span <= 65534) beat.dt = TW'($urandom_range(int'(span) - 1, int'(span) + 1));
        else beat.dt = TW'($urandom_range(65000, 65535));
        case ($urandom_range(0, 11))
            0: beat.sample = {1'b0, {(SW-1){1'b1}}};
            1: beat.sample = {1'b1, {(SW-1){1'b0}}};
            2: beat.sample = '0;
            3: beat.sample = '1;
            default: beat.sample = SW'($urandom);
        endcase
        return beat;
    endfunction

    function automatic sensor_beat_t make_beat(int smp, int dt);
        sensor_beat_t beat;
        beat.sample = smp[SW-1:0];
        beat.dt     = dt[TW-1:0];
        return beat;
    endfunction

    task automatic queue_beat(sensor_beat_t beat);
        pending_beats.push_back(beat);
        items_queued++;
    endtask

    task automatic write_tau(logic [vslp_pkg::TAU_WIDTH-1:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        tau_model = value;
    endtask

    // wait for every beat to be taken and every result to come back
    task automatic wait_idle();
        while (items_taken != items_queued || expected_outputs.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // input driver
    always @(negedge aclk) begin : drive_input
        sensor_beat_t beat;
        if (aresetn && (!s_tvalid || in_taken)) begin
            if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                beat = pending_beats.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= beat;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result ready, with one long hold-off to back the block up
    always @(negedge aclk) begin : drive_ready
        if (!hold_done && rx_count >= HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // monitor: predict on input beats, check on result beats
    always @(posedge aclk) begin : watch_beats
        logic signed [SW-1:0] want;
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                expected_outputs.push_back(advance_filter(sensor_beat_t'(s_tdata[SW+TW-1:0])));
                items_taken++;
            end
            if (m_tvalid && m_tready) begin
                rx_count++;
                if (expected_outputs.size() == 0) begin
                    $error("filtered: expected none, actual %0d", $signed(m_tdata[SW-1:0]));
                    fail_count++;
                end else begin
                    want = expected_outputs.pop_front();
                    if (m_tdata[SW-1:0] !== want) begin
                        $error("filtered: expected %0d, actual %0d", want,
                               $signed(m_tdata[SW-1:0]));
                        fail_count++;
                    end
                end
            end
        end
    end

    // run limit
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // stimulus sequence
    initial begin : run_phases
        logic [vslp_pkg::TAU_WIDTH-1:0] tau_plan[8];
        build_decay_lut();
        tau_plan[0] = vslp_pkg::TAU_RESET;
        tau_plan[1] = 1;
        tau_plan[2] = TAU_MAX;
        tau_plan[3] = 0;
        tau_plan[4] = vslp_pkg::TAU_WIDTH'($urandom_range(2, 2000));
        tau_plan[5] = vslp_pkg::TAU_WIDTH'($urandom);
        tau_plan[6] = 16;
        tau_plan[7] = 4096;

        send_idle_pct = 6;
        recv_idle_pct = 64;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, long step, zero step, boundary at reset tau
        queue_beat(make_beat(32767, 65535));
        queue_beat(make_beat(-32768, 0));
        queue_beat(make_beat(-32768, 16384));
        queue_beat(make_beat(32767, 16383));
        queue_beat(make_beat(-32768, 1));
        queue_beat(make_beat(0, 1024));
        queue_beat(make_beat(-1, 512));
        queue_beat(make_beat(1, 8192));
        queue_beat(make_beat(32767, 4096));
        queue_beat(make_beat(-32768, 100));
        queue_beat(make_beat(12345, 0));
        queue_beat(make_beat(-1, 65535));
        queue_beat(make_beat(16'h5555, 16'hAAAA));
        queue_beat(make_beat(16'hAAAA, 16'h5555));
        queue_beat(make_beat(-20000, 16385));
        wait_idle();

        // zero time constant acts as one
        write_tau('0);
        queue_beat(make_beat(1000, 0));
        queue_beat(make_beat(1000, 1));
        queue_beat(make_beat(-2000, 15));
        queue_beat(make_beat(-2000, 16));
        queue_beat(make_beat(32767, 8));
        wait_idle();

        // random phases over a spread of time constants
        for (int p = 0; p < 8; p++) begin
            if (p == 3) begin
                send_idle_pct = 64;
                recv_idle_pct = 6;
            end else if (p == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_tau(tau_plan[p]);
            for (int i = 0; i < PHASE_BEATS; i++) queue_beat(random_beat(tau_plan[p]));
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
